// File: sv/rdc_pkg.sv
package rdc_pkg;

  // Widths of the value path and of the digit stack
  localparam int unsigned VALUE_BITS  = 31;
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CNT_W       = $clog2(VALUE_BITS);

  // Radix limits and reset value
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = DIGIT_W'(2);
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = DIGIT_W'(36);
  localparam logic [DIGIT_W-1:0] RADIX_RESET = DIGIT_W'(10);

  // Result of one division step handed back to the sequencer
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_res_t;

endpackage

// File: sv/rdc_divider.sv
module rdc_divider
  import rdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [DIGIT_W-1:0]    divisor_i,
  output div_res_t              res_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [DIGIT_W:0]      trial;
  logic                  ge;

  // One quotient bit per cycle, restoring form
  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign ge    = (trial >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS - 1);
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_BITS-2:0], ge};
      rem_d  = ge ? DIGIT_W'(trial - {1'b0, divisor_i}) : trial[DIGIT_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quot_q;
  assign res_o.remainder = rem_q;

endmodule

// File: sv/rdc_stack.sv
module rdc_stack
  import rdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [DIGIT_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [DIGIT_W-1:0] rdata_o
);

  logic [DIGIT_W-1:0] mem_q [STACK_DEPTH];
  logic [DIGIT_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/radix_digit_converter.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[30:0] value
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata[5:0] digit, tlast last_digit
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_data_i radix
//
// Each digit of a value is formed in the shared divider, one quotient bit per
// cycle, and its remainder is pushed onto the digit stack; the stack is then
// popped to the output side. A zero value is accepted but gives no digits.
// Reset is asynchronous, active low; radix resets to 10, values 0..1 and
// 37..63 are held at 2 and 36. The input is not ready until all digits of the
// previous value are in the output register; output stalls hold the pop.
module radix_digit_converter
  import rdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] digit
  output logic        m_axis_tlast,   // last_digit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i      // radix
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_POP_RD = 2'd2;
  localparam logic [1:0] ST_POP_LD = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic [DIGIT_W-1:0]    radix_q;
  logic [DIGIT_W-1:0]    radix_sat;
  logic                  out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0]    out_digit_q, out_digit_d;
  logic                  out_last_q, out_last_d;

  logic                  in_req;
  logic                  out_free;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  div_res_t              div_res;
  logic                  push;
  logic                  pop_rd;
  logic [DIGIT_W-1:0]    stack_rdata;

  // Radix register, held to the legal range on write
  always_comb begin
    if (cfg_data_i < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (cfg_data_i > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= radix_sat;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    div_start    = 1'b0;
    div_dividend = div_res.quotient;
    push         = 1'b0;
    pop_rd       = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_digit_d  = out_digit_q;
    out_last_d   = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        depth_d      = '0;
        div_dividend = s_axis_tdata[VALUE_BITS-1:0];
        if (in_req && (s_axis_tdata[VALUE_BITS-1:0] != '0)) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          push    = 1'b1;
          depth_d = depth_q + DEPTH_W'(1);
          if ((div_res.quotient == '0) || (depth_q == DEPTH_W'(STACK_DEPTH - 1))) begin
            state_d = ST_POP_RD;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_POP_RD: begin
        if (out_free) begin
          pop_rd  = 1'b1;
          depth_d = depth_q - DEPTH_W'(1);
          state_d = ST_POP_LD;
        end
      end
      ST_POP_LD: begin
        out_valid_d = 1'b1;
        out_digit_d = stack_rdata;
        out_last_d  = (depth_q == '0);
        state_d     = (depth_q == '0) ? ST_IDLE : ST_POP_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
  end

  rdc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (radix_q),
    .res_o      (div_res)
  );

  rdc_stack u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (depth_q[ADDR_W-1:0]),
    .wdata_i (div_res.remainder),
    .re_i    (pop_rd),
    .raddr_i (depth_d[ADDR_W-1:0]),
    .rdata_o (stack_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - DIGIT_W){1'b0}}, out_digit_q};
  assign m_axis_tlast  = out_last_q;

  // Stack never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("digit stack depth beyond capacity");

  // Divider only restarted from idle or mid-conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (state_q == ST_IDLE || state_q == ST_DIV))
    else $error("divider started outside conversion");

  // A digit loaded with the stack empty is flagged last and ends the conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_LD && depth_q == '0) |=> (state_q == ST_IDLE && m_axis_tlast))
    else $error("last digit not flagged");

  // Popping never overwrites a waiting digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_LD) |-> $past(out_free))
    else $error("output register overwritten");

endmodule
